// File: hw/rtl/per_origin_replay_window_dedup_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the replay window dedup block
// Clocked concurrent assertion wrappers used by the RTL files.
// ----------------------------------------------------------------------------
`ifndef PER_ORIGIN_REPLAY_WINDOW_DEDUP_MACROS_SVH
`define PER_ORIGIN_REPLAY_WINDOW_DEDUP_MACROS_SVH

// Assertion that is switched off while reset is asserted
`define PRWD_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion that is checked during reset as well
`define PRWD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/prwd_pkg.sv
// ----------------------------------------------------------------------------
// Replay window dedup package
// Item types, verdict codes, controller command and status groups.
// ----------------------------------------------------------------------------
package prwd_pkg;

    // Field widths fixed by the item format
    localparam int ID_W   = 64;
    localparam int SEQ_W  = 32;
    localparam int SLOT_FIELD_W = 3;

    // Replay window length in sequence numbers
    localparam int WINDOW = 32;

    // Defaults for the top-level parameters
    localparam int PEER_SLOTS_DEF = 8;
    localparam int ID_BYTES_DEF   = 8;

    typedef enum logic [1:0] {
        VERDICT_FRESH = 2'd0,
        VERDICT_DUP   = 2'd1,
        VERDICT_ECHO  = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [ID_W-1:0]  origin_id;
        logic [SEQ_W-1:0] sequence_req;
    } in_item_t;

    typedef struct packed {
        verdict_t                 verdict;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic                     new_peer;
        logic                     evicted;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // latch the accepted item
        logic search_clr;  // clear search results and the scan index
        logic scan_rd;     // read the table at the scan index, then advance
        logic echo_out;    // load an own-echo result into the output register
        logic commit;      // write back the chosen slot and load the result
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_echo;     // latched origin equals own id
        logic out_free;    // output register can take a result this cycle
        logic scan_last;   // scan index is at the last slot
    } ctrl_sts_t;

endpackage

// File: hw/rtl/prwd_ctrl.sv
// ----------------------------------------------------------------------------
// Replay window dedup controller
// Sequences echo check, table scan, drain and write back for each item.
// ----------------------------------------------------------------------------
module prwd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  prwd_pkg::ctrl_sts_t sts,
    output prwd_pkg::ctrl_cmd_t cmd
);
    import prwd_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_UPDATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next     = state_reg;
        cmd            = '0;
        s_ready        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.is_echo) begin
                    if (sts.out_free) begin
                        cmd.echo_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.search_clr = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan_rd = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last slot's read data is compared on this edge
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/prwd_datapath.sv
// ----------------------------------------------------------------------------
// Replay window dedup datapath
// Peer table memory, scan compare stage, window update and output register.
// ----------------------------------------------------------------------------
`include "per_origin_replay_window_dedup_macros.svh"

module prwd_datapath #(
    parameter int PEER_SLOTS = prwd_pkg::PEER_SLOTS_DEF,
    parameter int ID_BYTES   = prwd_pkg::ID_BYTES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  prwd_pkg::ctrl_cmd_t  cmd,
    output prwd_pkg::ctrl_sts_t  sts,
    input  prwd_pkg::in_item_t   s_data,
    input  logic                 cfg_wr_en,
    input  logic [prwd_pkg::ID_W-1:0] cfg_wr_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output prwd_pkg::out_item_t  m_data
);
    import prwd_pkg::*;

    localparam int ID_BITS = ID_BYTES * 8;
    localparam int SLOT_W  = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int SHIFT_W = $clog2(SEQ_W);
    localparam int WORD_W  = ID_BITS + 3 * SEQ_W;

    // Configuration and latched item
    logic [ID_BITS-1:0] own_id_reg;
    logic [ID_BITS-1:0] org_reg;
    logic [SEQ_W-1:0]   seq_reg;

    // Peer table: {origin, high seq, seen mask, last use}
    logic [WORD_W-1:0]     table_mem [PEER_SLOTS];
    logic [WORD_W-1:0]     rd_word_reg;
    logic [PEER_SLOTS-1:0] slot_valid_reg;
    logic [SEQ_W-1:0]      use_clock_reg;

    // Scan pipeline
    logic [SLOT_W-1:0] scan_idx_reg;
    logic              rd_pend_reg;
    logic [SLOT_W-1:0] rd_idx_reg;

    // Search results
    logic              hit_found_reg;
    logic [SLOT_W-1:0] hit_idx_reg;
    logic [SEQ_W-1:0]  hit_high_reg;
    logic [SEQ_W-1:0]  hit_mask_reg;
    logic              free_found_reg;
    logic [SLOT_W-1:0] free_idx_reg;
    logic              old_found_reg;
    logic [SLOT_W-1:0] old_idx_reg;
    logic [SEQ_W-1:0]  old_last_reg;

    // Output register
    logic      m_valid_reg;
    out_item_t m_data_reg;

    logic [ID_BITS-1:0] rd_origin;
    logic [SEQ_W-1:0]   rd_high;
    logic [SEQ_W-1:0]   rd_mask;
    logic [SEQ_W-1:0]   rd_last;
    logic               rd_slot_valid;

    logic [SLOT_W-1:0]   sel_idx;
    logic [SLOT_W+2:0]   sel_ext;
    logic                evict;
    logic [SEQ_W-1:0]    use_next;
    logic [SEQ_W-1:0]    fwd_dist;
    logic [SEQ_W-1:0]    fwd_dist_m1;
    logic [SEQ_W-1:0]    back_dist;
    logic [SEQ_W-1:0]    back_dist_m1;
    logic [SEQ_W-1:0]    back_bit;
    logic [SEQ_W-1:0]    wr_high;
    logic [SEQ_W-1:0]    wr_mask;
    verdict_t            wr_verdict;
    logic [WORD_W-1:0]   wr_word;

    // Status to controller
    assign sts.is_echo   = (org_reg == own_id_reg);
    assign sts.out_free  = !m_valid_reg || m_ready;
    assign sts.scan_last = (scan_idx_reg == SLOT_W'(PEER_SLOTS - 1));

    // Own id register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_id_reg <= '0;
        end else if (cfg_wr_en) begin
            own_id_reg <= cfg_wr_data[ID_BITS-1:0];
        end
    end

    // Item latch, only the low id bytes take part
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            org_reg <= s_data.origin_id[ID_BITS-1:0];
            seq_reg <= s_data.sequence_req;
        end
    end

    // Table memory: one read and one write port, read data registered
    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_word_reg <= table_mem[scan_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            table_mem[sel_idx] <= wr_word;
        end
    end

    assign rd_origin     = rd_word_reg[WORD_W-1 -: ID_BITS];
    assign rd_high       = rd_word_reg[3*SEQ_W-1 -: SEQ_W];
    assign rd_mask       = rd_word_reg[2*SEQ_W-1 -: SEQ_W];
    assign rd_last       = rd_word_reg[SEQ_W-1:0];
    assign rd_slot_valid = slot_valid_reg[rd_idx_reg];

    // Scan index and read pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_idx_reg <= '0;
            rd_pend_reg  <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.scan_rd;
            if (cmd.search_clr) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_rd) begin
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.scan_rd) begin
            rd_idx_reg <= scan_idx_reg;
        end
    end

    // Compare stage: hit, lowest free slot, least recently used slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end else if (cmd.search_clr) begin
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            old_found_reg  <= 1'b0;
        end else if (rd_pend_reg && !hit_found_reg) begin
            if (rd_slot_valid) begin
                if (rd_origin == org_reg) begin
                    hit_found_reg <= 1'b1;
                    hit_idx_reg   <= rd_idx_reg;
                    hit_high_reg  <= rd_high;
                    hit_mask_reg  <= rd_mask;
                end else if (!old_found_reg || (rd_last < old_last_reg)) begin
                    old_found_reg <= 1'b1;
                    old_idx_reg   <= rd_idx_reg;
                    old_last_reg  <= rd_last;
                end
            end else if (!free_found_reg) begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= rd_idx_reg;
            end
        end
    end

    // Slot choice
    always_comb begin
        if (hit_found_reg) begin
            sel_idx = hit_idx_reg;
        end else if (free_found_reg) begin
            sel_idx = free_idx_reg;
        end else if (old_found_reg) begin
            sel_idx = old_idx_reg;
        end else begin
            sel_idx = '0;
        end
    end

    assign evict    = !hit_found_reg && !free_found_reg;
    assign sel_ext  = {3'b000, sel_idx};
    assign use_next = use_clock_reg + 1'b1;

    // Window update
    assign fwd_dist     = seq_reg - hit_high_reg;
    assign fwd_dist_m1  = fwd_dist - 1'b1;
    assign back_dist    = hit_high_reg - seq_reg;
    assign back_dist_m1 = back_dist - 1'b1;
    assign back_bit     = SEQ_W'(1) << back_dist_m1[SHIFT_W-1:0];

    always_comb begin
        wr_high    = hit_high_reg;
        wr_mask    = hit_mask_reg;
        wr_verdict = VERDICT_FRESH;
        if (!hit_found_reg) begin
            // new peer starts with an empty window
            wr_high = seq_reg;
            wr_mask = '0;
        end else if (seq_reg > hit_high_reg) begin
            wr_high = seq_reg;
            if (fwd_dist >= SEQ_W'(WINDOW)) begin
                wr_mask = '0;
            end else begin
                wr_mask = (hit_mask_reg << fwd_dist[SHIFT_W-1:0])
                        | (SEQ_W'(1) << fwd_dist_m1[SHIFT_W-1:0]);
            end
        end else if (seq_reg == hit_high_reg) begin
            wr_verdict = VERDICT_DUP;
        end else if (back_dist > SEQ_W'(WINDOW)) begin
            // too far behind the window
            wr_verdict = VERDICT_DUP;
        end else if ((hit_mask_reg & back_bit) != '0) begin
            wr_verdict = VERDICT_DUP;
        end else begin
            wr_mask = hit_mask_reg | back_bit;
        end
    end

    assign wr_word = {org_reg, wr_high, wr_mask, use_next};

    // Valid bits and use clock
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            use_clock_reg  <= '0;
        end else if (cmd.commit) begin
            slot_valid_reg[sel_idx] <= 1'b1;
            use_clock_reg           <= use_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.echo_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.echo_out) begin
            m_data_reg.verdict  <= VERDICT_ECHO;
            m_data_reg.slot     <= '0;
            m_data_reg.new_peer <= 1'b0;
            m_data_reg.evicted  <= 1'b0;
        end else if (cmd.commit) begin
            m_data_reg.verdict  <= wr_verdict;
            m_data_reg.slot     <= sel_ext[SLOT_FIELD_W-1:0];
            m_data_reg.new_peer <= !hit_found_reg;
            m_data_reg.evicted  <= evict;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    `PRWD_ASSERT(a_load_when_free, aclk, aresetn, (cmd.commit || cmd.echo_out) |-> (!m_valid_reg || m_ready), "result loaded while output register busy")
    `PRWD_ASSERT(a_slot_marked, aclk, aresetn, cmd.commit |=> slot_valid_reg[$past(sel_idx)], "committed slot not marked valid")
    `PRWD_ASSERT(a_clock_hold, aclk, aresetn, !cmd.commit |=> $stable(use_clock_reg), "use clock moved without a commit")
    `PRWD_ASSERT(a_evict_is_new, aclk, aresetn, m_valid_reg |-> (!m_data_reg.evicted || m_data_reg.new_peer), "eviction without new peer")
    `PRWD_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid_reg, "output valid survived reset")

endmodule

// File: hw/rtl/per_origin_replay_window_dedup.sv
// ----------------------------------------------------------------------------
// Per-origin replay window dedup
// Classifies each received frame as fresh, duplicate or own echo using a
// 32-entry sliding window per peer in a small least recently used table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_data carries origin_id and sequence_req.
//   Result channel m_valid/m_ready/m_data carries verdict, slot, new_peer and
//   evicted, one result per item, in item order.
//   cfg_wr_en/cfg_wr_data write own_id; write it while idle.
// Sequence:
//   An own echo is loaded into the output register from the check state once
//   it is free. Any other item passes the check, scan, drain and update
//   states and is loaded in update once the output register is free: the
//   table is read one slot per cycle with registered read data, then the
//   chosen slot is written back as the result is loaded. One item is in work
//   at a time; s_ready is high only between items.
// Reset:
//   aresetn (synchronous, active low) clears the slot valid bits, the use
//   clock, own_id and the output register. Table contents need no clearing.
// Stall:
//   A result waits in the output register while m_ready is low; the next item
//   is still accepted and worked on, and holds before write back until the
//   output register is free.
// ----------------------------------------------------------------------------
module per_origin_replay_window_dedup #(
    parameter int PEER_SLOTS = prwd_pkg::PEER_SLOTS_DEF,
    parameter int ID_BYTES   = prwd_pkg::ID_BYTES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  prwd_pkg::in_item_t        s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output prwd_pkg::out_item_t       m_data,
    input  logic                      cfg_wr_en,
    input  logic [prwd_pkg::ID_W-1:0] cfg_wr_data
);
    import prwd_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // Sequencer
    prwd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Table, window logic and output register
    prwd_datapath #(
        .PEER_SLOTS (PEER_SLOTS),
        .ID_BYTES   (ID_BYTES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .s_data      (s_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
